FILE: rtl/quadtree_buddy_allocator_assert.svh
// Assertion macros shared by the quadtree buddy allocator modules.
`ifndef QUADTREE_BUDDY_ALLOCATOR_ASSERT_SVH
`define QUADTREE_BUDDY_ALLOCATOR_ASSERT_SVH

// Check that a condition holds at every clock edge outside reset.
`define QBA_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("quadtree buddy allocator check failed");

// Check a same-cycle implication outside reset.
`define QBA_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("quadtree buddy allocator check failed");

// Check a next-cycle implication outside reset.
`define QBA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("quadtree buddy allocator check failed");

`endif

FILE: rtl/qba_pkg.sv
// Types, codes and controller/datapath interface of the quadtree buddy allocator.
`timescale 1ns / 1ps
`default_nettype none

package qba_pkg;

   typedef logic [14:0] node_type;
   typedef logic [6:0]  pos_type;
   typedef logic [7:0]  mask_type;
   typedef logic [2:0]  lvl_type;
   typedef logic [1:0]  lane_type;
   typedef logic [3:0][7:0] row_type;

   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam mask_type MASK_FREE = 8'hFF;
   localparam mask_type MASK_USED = 8'h00;

   typedef struct packed {
      logic clear_wr;
      logic load;
      logic desc_step;
      logic mark;
      logic up_rd;
      logic up_wr;
      logic respond;
      logic resp_ok;
   } cmd_type;

   typedef struct packed {
      logic is_release;
      logic lvl_bad;
      logic idx_bad;
      logic root_hit;
      logic lvl_zero;
      logic found;
      logic desc_last;
      logic up_same;
      logic up_last;
      logic clear_last;
   } stat_type;

endpackage

`default_nettype wire

FILE: rtl/qba_dpath.sv
// Datapath: mask memory, root mask, descent walker, upward refresh and result word.
`timescale 1ns / 1ps
`default_nettype none

`include "quadtree_buddy_allocator_assert.svh"

module qba_dpath #(
   parameter int TREE_LEVELS = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire qba_pkg::cmd_type   cmd,
   output qba_pkg::stat_type       stat,
   input  wire logic               req_opcode,
   input  wire qba_pkg::lvl_type   req_level,
   input  wire qba_pkg::node_type  req_node_index,
   output logic                    rsp_strobe,
   output logic                    rsp_success,
   output qba_pkg::pos_type        rsp_x_pos,
   output qba_pkg::pos_type        rsp_y_pos,
   output qba_pkg::node_type       rsp_granted_node
);

   localparam int NODE_COUNT = ((1 << (2 * TREE_LEVELS)) - 1) / 3;
   localparam int ROWS       = ((1 << (2 * (TREE_LEVELS - 1))) - 1) / 3;
   localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;

   typedef logic [ROW_W-1:0] row_addr_type;

   qba_pkg::row_type  mem_ff [ROWS];
   qba_pkg::row_type  rd_a_ff;
   qba_pkg::row_type  rd_b_ff;

   qba_pkg::mask_type root_ff;
   row_addr_type      clr_ff;
   logic              op_ff;
   qba_pkg::lvl_type  lvl_ff;
   qba_pkg::lvl_type  cur_ff;
   qba_pkg::node_type node_ff;
   qba_pkg::pos_type  x_ff;
   qba_pkg::pos_type  y_ff;
   qba_pkg::node_type grant_ff;
   logic              lvl_bad_ff;
   logic              idx_bad_ff;

   logic              rsp_strobe_ff;
   logic              rsp_success_ff;
   qba_pkg::pos_type  rsp_x_ff;
   qba_pkg::pos_type  rsp_y_ff;
   qba_pkg::node_type rsp_node_ff;

   logic [15:0]       first_idx;
   qba_pkg::lvl_type  rel_lvl;

   qba_pkg::node_type node_m1;
   qba_pkg::node_type par_node;
   qba_pkg::node_type par_m1;
   logic              par_is_root;
   logic              node_is_root;
   row_addr_type      rd_a_addr;
   row_addr_type      rd_b_addr;

   row_addr_type      wr_addr;
   logic [3:0]        wr_be;
   qba_pkg::row_type  wr_data;

   qba_pkg::mask_type mark_val;
   qba_pkg::mask_type and_m;
   qba_pkg::mask_type or_m;
   qba_pkg::mask_type low_mask;
   qba_pkg::mask_type new_mask;
   qba_pkg::mask_type parent_mask;
   qba_pkg::lvl_type  s_m1;

   logic [3:0]        hit;
   qba_pkg::lane_type q_sel;
   qba_pkg::pos_type  stride;
   qba_pkg::node_type next_node;
   logic              alloc_ok;

   // level of a released node from the heap index range
   always_comb begin
      first_idx = 16'd1;
      rel_lvl   = '0;
      for (int d = 1; d < TREE_LEVELS; d++) begin
         if ({1'b0, req_node_index} >= first_idx) begin
            rel_lvl = qba_pkg::lvl_type'(d);
         end
         first_idx = {first_idx[13:0], 2'b01};
      end
   end

   assign node_m1      = node_ff - qba_pkg::node_type'(1);
   assign par_node     = {2'b00, node_m1[14:2]};
   assign par_m1       = par_node - qba_pkg::node_type'(1);
   assign par_is_root  = (par_node == '0);
   assign node_is_root = (node_ff == '0);

   assign rd_a_addr = cmd.up_rd ? row_addr_type'(par_node) : row_addr_type'(node_ff);
   assign rd_b_addr = row_addr_type'({2'b00, par_m1[14:2]});

   assign mark_val = (op_ff == qba_pkg::OP_RELEASE) ? qba_pkg::MASK_FREE
                                                      : qba_pkg::MASK_USED;

   // upward refresh of the parent mask
   assign and_m    = rd_a_ff[0] & rd_a_ff[1] & rd_a_ff[2] & rd_a_ff[3];
   assign or_m     = rd_a_ff[0] | rd_a_ff[1] | rd_a_ff[2] | rd_a_ff[3];
   assign s_m1     = lvl_ff - qba_pkg::lvl_type'(1);
   assign low_mask = (qba_pkg::mask_type'(1) << lvl_ff) - qba_pkg::mask_type'(1);
   assign new_mask = and_m[s_m1] ? or_m : (or_m & ~low_mask);
   assign parent_mask = par_is_root ? root_ff : rd_b_ff[par_m1[1:0]];

   // descent: first child lane that holds the requested bit
   always_comb begin
      for (int q = 0; q < 4; q++) begin
         hit[q] = rd_a_ff[q][lvl_ff];
      end
      priority if (hit[0]) begin
         q_sel = 2'd0;
      end else if (hit[1]) begin
         q_sel = 2'd1;
      end else if (hit[2]) begin
         q_sel = 2'd2;
      end else begin
         q_sel = 2'd3;
      end
   end

   assign stride    = qba_pkg::pos_type'(1)
                      << (qba_pkg::lvl_type'(TREE_LEVELS - 2) - cur_ff);
   assign next_node = {node_ff[12:0], 2'b00} + qba_pkg::node_type'(1)
                      + qba_pkg::node_type'(q_sel);

   // memory write port
   always_comb begin
      wr_addr = clr_ff;
      wr_be   = 4'b0000;
      wr_data = '0;
      priority if (cmd.clear_wr) begin
         wr_be   = 4'b1111;
         wr_data = {4{qba_pkg::MASK_FREE}};
      end else if (cmd.mark && !node_is_root) begin
         wr_addr = row_addr_type'(par_node);
         wr_be   = 4'b0001 << node_m1[1:0];
         wr_data = {4{mark_val}};
      end else if (cmd.up_wr && !par_is_root) begin
         wr_addr = row_addr_type'({2'b00, par_m1[14:2]});
         wr_be   = 4'b0001 << par_m1[1:0];
         wr_data = {4{new_mask}};
      end else begin
         wr_be   = 4'b0000;
      end
   end

   always_ff @(posedge clock) begin
      for (int b = 0; b < 4; b++) begin
         if (wr_be[b]) begin
            mem_ff[wr_addr][b] <= wr_data[b];
         end
      end
      rd_a_ff <= mem_ff[rd_a_addr];
      rd_b_ff <= mem_ff[rd_b_addr];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff       <= qba_pkg::MASK_FREE;
         clr_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.respond;
         if (cmd.clear_wr) begin
            clr_ff <= clr_ff + row_addr_type'(1);
         end
         if (cmd.mark && node_is_root) begin
            root_ff <= mark_val;
         end else if (cmd.up_wr && par_is_root) begin
            root_ff <= new_mask;
         end
      end
   end

   assign alloc_ok = cmd.resp_ok && (op_ff == qba_pkg::OP_ALLOC);

   // item payload and result word
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= req_opcode;
         lvl_ff     <= (req_opcode == qba_pkg::OP_RELEASE) ? rel_lvl : req_level;
         node_ff    <= (req_opcode == qba_pkg::OP_RELEASE) ? req_node_index : '0;
         cur_ff     <= '0;
         x_ff       <= '0;
         y_ff       <= '0;
         lvl_bad_ff <= ({1'b0, req_level} >= 4'(TREE_LEVELS));
         idx_bad_ff <= ({1'b0, req_node_index} >= 16'(NODE_COUNT));
      end
      if (cmd.desc_step) begin
         node_ff <= next_node;
         cur_ff  <= cur_ff + qba_pkg::lvl_type'(1);
         if (q_sel[0]) begin
            x_ff <= x_ff + stride;
         end
         if (q_sel[1]) begin
            y_ff <= y_ff + stride;
         end
      end
      if (cmd.mark) begin
         grant_ff <= node_ff;
      end
      if (cmd.up_wr) begin
         node_ff <= par_node;
         lvl_ff  <= s_m1;
      end
      if (cmd.respond) begin
         rsp_success_ff <= cmd.resp_ok;
         rsp_x_ff       <= alloc_ok ? x_ff : '0;
         rsp_y_ff       <= alloc_ok ? y_ff : '0;
         rsp_node_ff    <= alloc_ok ? grant_ff : '0;
      end
   end

   assign stat.is_release = (op_ff == qba_pkg::OP_RELEASE);
   assign stat.lvl_bad    = lvl_bad_ff;
   assign stat.idx_bad    = idx_bad_ff;
   assign stat.root_hit   = root_ff[lvl_ff];
   assign stat.lvl_zero   = (lvl_ff == '0);
   assign stat.found      = |hit;
   assign stat.desc_last  = ((cur_ff + qba_pkg::lvl_type'(1)) == lvl_ff);
   assign stat.up_same    = (new_mask == parent_mask);
   assign stat.up_last    = (lvl_ff == qba_pkg::lvl_type'(1));
   assign stat.clear_last = (clr_ff == row_addr_type'(ROWS - 1));

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_success      = rsp_success_ff;
   assign rsp_x_pos        = rsp_x_ff;
   assign rsp_y_pos        = rsp_y_ff;
   assign rsp_granted_node = rsp_node_ff;

   `QBA_ASSERT_IMPLY(a_fail_word_zero, clock, reset, rsp_strobe_ff && !rsp_success_ff, (rsp_x_ff == '0) && (rsp_y_ff == '0) && (rsp_node_ff == '0))
   `QBA_ASSERT_NEXT(a_refresh_climbs, clock, reset, cmd.up_wr, lvl_ff == ($past(lvl_ff) - qba_pkg::lvl_type'(1)))
   `QBA_ASSERT_IMPLY(a_mark_at_target, clock, reset, cmd.mark && (op_ff == qba_pkg::OP_ALLOC), cur_ff == lvl_ff)

endmodule

`default_nettype wire

FILE: rtl/qba_ctrl.sv
// Controller: sequences clearing, descent, marking, upward refresh and the result word.
`timescale 1ns / 1ps
`default_nettype none

`include "quadtree_buddy_allocator_assert.svh"

module qba_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_start,
   output logic                   busy,
   output qba_pkg::cmd_type       cmd,
   input  wire qba_pkg::stat_type stat
);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_DRD,
      ST_DEV,
      ST_MARK,
      ST_URD,
      ST_UEV,
      ST_DONE,
      ST_FAIL
   } state_type;

   state_type state_ff;
   logic      busy_ff;

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_CLEAR: cmd.clear_wr  = 1'b1;
         ST_IDLE:  cmd.load      = req_start;
         ST_DEV:   cmd.desc_step = stat.found;
         ST_MARK:  cmd.mark      = 1'b1;
         ST_URD:   cmd.up_rd     = 1'b1;
         ST_UEV:   cmd.up_wr     = !stat.up_same;
         ST_DONE: begin
            cmd.respond = 1'b1;
            cmd.resp_ok = 1'b1;
         end
         ST_FAIL:  cmd.respond   = 1'b1;
         default:  cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         busy_ff  <= 1'b1;
      end else begin
         unique case (state_ff)
            ST_CLEAR: begin
               if (stat.clear_last) begin
                  state_ff <= ST_IDLE;
                  busy_ff  <= 1'b0;
               end
            end
            ST_IDLE: begin
               if (req_start) begin
                  state_ff <= ST_CHECK;
                  busy_ff  <= 1'b1;
               end
            end
            ST_CHECK: begin
               priority if (stat.is_release) begin
                  state_ff <= stat.idx_bad ? ST_FAIL : ST_MARK;
               end else if (stat.lvl_bad || !stat.root_hit) begin
                  state_ff <= ST_FAIL;
               end else if (stat.lvl_zero) begin
                  state_ff <= ST_MARK;
               end else begin
                  state_ff <= ST_DRD;
               end
            end
            ST_DRD: state_ff <= ST_DEV;
            ST_DEV: begin
               priority if (!stat.found) begin
                  state_ff <= ST_FAIL;
               end else if (stat.desc_last) begin
                  state_ff <= ST_MARK;
               end else begin
                  state_ff <= ST_DRD;
               end
            end
            ST_MARK: state_ff <= stat.lvl_zero ? ST_DONE : ST_URD;
            ST_URD:  state_ff <= ST_UEV;
            ST_UEV: begin
               if (stat.up_same || stat.up_last) begin
                  state_ff <= ST_DONE;
               end else begin
                  state_ff <= ST_URD;
               end
            end
            ST_DONE, ST_FAIL: begin
               state_ff <= ST_IDLE;
               busy_ff  <= 1'b0;
            end
            default: begin
               state_ff <= ST_IDLE;
               busy_ff  <= 1'b0;
            end
         endcase
      end
   end

   assign busy = busy_ff;

   `QBA_ASSERT_NEXT(a_respond_frees, clock, reset, cmd.respond, !busy_ff)
   `QBA_ASSERT_ALWAYS(a_one_writer, clock, reset, $onehot0({cmd.clear_wr, cmd.mark, cmd.up_wr}))
   `QBA_ASSERT_IMPLY(a_load_when_free, clock, reset, cmd.load, !busy_ff)

endmodule

`default_nettype wire

FILE: rtl/quadtree_buddy_allocator.sv
// Top level of the two-dimensional quadtree buddy allocator.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   A request word is taken at a rising edge with req_start high and busy low.
//   req_opcode selects allocate (square of req_level) or release (req_node_index).
//   Each request gives exactly one result word on the rsp_ ports, marked by
//   rsp_strobe for one cycle; the receiver cannot stall and must take it then.
//   Allocate returns the square's x/y offset and heap node for a later release;
//   a failed allocate or an out-of-range release returns success 0 and zeros.
// Sequence:
//   From accept to rsp_strobe the block walks L descent steps, L the descent
//   depth (requested level), then U refresh steps up the tree (at most the
//   node level, fewer when a parent mask stops changing); release has L = 0.
//   Each step rests on the mask memory: one registered row read of four
//   sibling masks.
//   busy drops in the cycle of rsp_strobe, so the next request can follow.
// Reset:
//   After reset the block sweeps the mask memory to all-free, one row of four
//   masks per cycle ((4^(TREE_LEVELS-1)-1)/3 rows, 5461 at 8 levels), with
//   busy high until the sweep ends.
module quadtree_buddy_allocator #(
   parameter int TREE_LEVELS = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_start,
   output logic                   busy,
   input  wire logic              req_opcode,
   input  wire qba_pkg::lvl_type  req_level,
   input  wire qba_pkg::node_type req_node_index,
   output logic                   rsp_strobe,
   output logic                   rsp_success,
   output qba_pkg::pos_type       rsp_x_pos,
   output qba_pkg::pos_type       rsp_y_pos,
   output qba_pkg::node_type      rsp_granted_node
);

   qba_pkg::cmd_type  cmd;
   qba_pkg::stat_type stat;

   qba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_start (req_start),
      .busy      (busy),
      .cmd       (cmd),
      .stat      (stat)
   );

   qba_dpath #(
      .TREE_LEVELS (TREE_LEVELS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_opcode       (req_opcode),
      .req_level        (req_level),
      .req_node_index   (req_node_index),
      .rsp_strobe       (rsp_strobe),
      .rsp_success      (rsp_success),
      .rsp_x_pos        (rsp_x_pos),
      .rsp_y_pos        (rsp_y_pos),
      .rsp_granted_node (rsp_granted_node)
   );

endmodule

`default_nettype wire
